/* hw/rtl/tfn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tfn_pkg;

  // Default configuration
  localparam int COORD_BITS_DEF  = 24;
  localparam int NORMAL_FRAC_DEF = 16;

  // Occupancy flags of the front/back queue
  typedef struct packed {
    logic full;
    logic empty;
  } tfn_fifo_status_t;

  // Control that travels beside the data in the back pipeline
  typedef struct packed {
    logic valid;
    logic degenerate;
  } tfn_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/tfn_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module tfn_front #(
  parameter int COORD_BITS = 24
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         accept,
  input  wire logic                         queue_full,
  output logic                              stall,
  output logic                              push,
  output logic [3*(2*COORD_BITS+1)+3:0]     item,
  input  wire logic signed [COORD_BITS-1:0] v1x,
  input  wire logic signed [COORD_BITS-1:0] v1y,
  input  wire logic signed [COORD_BITS-1:0] v1z,
  input  wire logic signed [COORD_BITS-1:0] v2x,
  input  wire logic signed [COORD_BITS-1:0] v2y,
  input  wire logic signed [COORD_BITS-1:0] v2z,
  input  wire logic signed [COORD_BITS-1:0] v3x,
  input  wire logic signed [COORD_BITS-1:0] v3y,
  input  wire logic signed [COORD_BITS-1:0] v3z
);
  import tfn_pkg::*;

  localparam int EW = COORD_BITS + 1;    // edge vector width
  localparam int PW = 2 * EW;            // product / cross width
  localparam int MW = 2 * COORD_BITS + 1; // cross magnitude width

  logic en;
  logic s1_valid, s2_valid, s3_valid;
  logic signed [EW-1:0] ax, ay, az, bx, by, bz;
  logic signed [PW-1:0] p_x1, p_x2, p_y1, p_y2, p_z1, p_z2;
  logic signed [PW-1:0] c_x, c_y, c_z;
  logic [MW-1:0] m_x, m_y, m_z;
  logic [3*MW+3:0] s3_item;

  assign stall = s3_valid & queue_full;
  assign en    = ~stall;
  assign push  = s3_valid & ~queue_full;
  assign item  = s3_item;

  // edge vectors a = v1 - v3, b = v3 - v2
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
    end
    if (en) begin
      ax <= EW'(v1x) - EW'(v3x);
      ay <= EW'(v1y) - EW'(v3y);
      az <= EW'(v1z) - EW'(v3z);
      bx <= EW'(v3x) - EW'(v2x);
      by <= EW'(v3y) - EW'(v2y);
      bz <= EW'(v3z) - EW'(v2z);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
    if (en) begin
      p_x1 <= ay * bz;
      p_x2 <= az * by;
      p_y1 <= az * bx;
      p_y2 <= ax * bz;
      p_z1 <= ax * by;
      p_z2 <= ay * bx;
    end
  end

  // exact difference always fits in PW bits
  assign c_x = p_x1 - p_x2;
  assign c_y = p_y1 - p_y2;
  assign c_z = p_z1 - p_z2;
  assign m_x = c_x[PW-1] ? MW'(-c_x) : MW'(c_x);
  assign m_y = c_y[PW-1] ? MW'(-c_y) : MW'(c_y);
  assign m_z = c_z[PW-1] ? MW'(-c_z) : MW'(c_z);

  // classify: zero cross product is degenerate
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
    if (en) begin
      s3_item <= {(c_x == '0) && (c_y == '0) && (c_z == '0),
                  c_z[PW-1], c_y[PW-1], c_x[PW-1], m_z, m_y, m_x};
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tfn_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module tfn_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output tfn_pkg::tfn_fifo_status_t status
);
  import tfn_pkg::*;

  logic [WIDTH-1:0] entry [0:1];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);
  assign pop_data     = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && status.full))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && status.empty))
    else $error("queue underflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 2'd1))
    else $error("queue count did not advance");

endmodule

`default_nettype wire

/* hw/rtl/tfn_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// One component: D = floor(c^2 * 2^(2F) / s) by long division, then
// q = isqrt(D), one quotient or root bit per stage.
module tfn_unit #(
  parameter int NORMAL_FRAC = 16,
  parameter int MAG_BITS    = 49
) (
  input  wire logic                      clk,
  input  wire logic [2*MAG_BITS-1:0]     csq,
  input  wire logic [2*MAG_BITS+1:0]     sum,
  input  wire logic                      neg,
  output logic [NORMAL_FRAC:0]           mag,
  output logic                           mag_neg
);
  import tfn_pkg::*;

  localparam int SQW = 2 * MAG_BITS;
  localparam int SW  = SQW + 2;
  localparam int RW  = SW + 1;
  localparam int DS  = 2 * NORMAL_FRAC + 1;
  localparam int SS  = NORMAL_FRAC + 1;
  localparam int QW  = NORMAL_FRAC + 1;
  localparam int TW  = 2 * NORMAL_FRAC + 3;

  logic [RW-1:0] rem  [1:DS];
  logic [SW-1:0] sd   [1:DS];
  logic [DS-1:0] quo  [1:DS];
  logic          dng  [1:DS];

  logic [DS-1:0] rd   [1:SS];
  logic [QW-1:0] rq   [1:SS];
  logic [TW-1:0] rsq  [1:SS];
  logic          rng  [1:SS];

  genvar i, j;
  generate
    for (i = 0; i < DS; i++) begin : g_div
      logic [RW-1:0] trial;
      logic [SW-1:0] s_src;
      logic [DS-1:0] q_src;
      logic          n_src;
      logic          ge;
      if (i == 0) begin : g_first
        assign trial = RW'(csq);
        assign s_src = sum;
        assign q_src = '0;
        assign n_src = neg;
      end else begin : g_next
        assign trial = {rem[i][RW-2:0], 1'b0};
        assign s_src = sd[i];
        assign q_src = quo[i];
        assign n_src = dng[i];
      end
      assign ge = (trial >= {1'b0, s_src});
      always_ff @(posedge clk) begin
        rem[i+1] <= ge ? (trial - {1'b0, s_src}) : trial;
        sd[i+1]  <= s_src;
        quo[i+1] <= {q_src[DS-2:0], ge};
        dng[i+1] <= n_src;
      end
    end

    for (j = 0; j < SS; j++) begin : g_sqrt
      localparam int B = NORMAL_FRAC - j;
      logic [DS-1:0] d_src;
      logic [QW-1:0] q_src;
      logic [TW-1:0] sq_src;
      logic          n_src;
      logic [TW-1:0] t2;
      logic          take;
      if (j == 0) begin : g_first
        assign d_src  = quo[DS];
        assign q_src  = '0;
        assign sq_src = '0;
        assign n_src  = dng[DS];
      end else begin : g_next
        assign d_src  = rd[j];
        assign q_src  = rq[j];
        assign sq_src = rsq[j];
        assign n_src  = rng[j];
      end
      // (q + 2^B)^2 = q^2 + q*2^(B+1) + 2^(2B)
      assign t2   = sq_src + (TW'(q_src) << (B + 1)) + (TW'(1) << (2 * B));
      assign take = (t2 <= TW'(d_src));
      always_ff @(posedge clk) begin
        rd[j+1]  <= d_src;
        rq[j+1]  <= take ? (q_src | (QW'(1) << B)) : q_src;
        rsq[j+1] <= take ? t2 : sq_src;
        rng[j+1] <= n_src;
      end
    end
  endgenerate

  assign mag     = rq[SS];
  assign mag_neg = rng[SS];

endmodule

`default_nettype wire

/* hw/rtl/tfn_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module tfn_back #(
  parameter int COORD_BITS  = 24,
  parameter int NORMAL_FRAC = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire logic [3*(2*COORD_BITS+1)+3:0]  in_item,
  output logic                                done,
  output logic signed [NORMAL_FRAC+1:0]       nx,
  output logic signed [NORMAL_FRAC+1:0]       ny,
  output logic signed [NORMAL_FRAC+1:0]       nz,
  output logic                                deg
);
  import tfn_pkg::*;

  localparam int MW  = 2 * COORD_BITS + 1;
  localparam int H   = (MW + 1) / 2;
  localparam int HW  = MW - H;
  localparam int SQW = 2 * MW;
  localparam int SW  = SQW + 2;
  localparam int OW  = NORMAL_FRAC + 2;
  localparam int QW  = NORMAL_FRAC + 1;
  localparam int UL  = (2 * NORMAL_FRAC + 1) + (NORMAL_FRAC + 1);

  logic [MW-1:0] m_in [0:2];
  logic [2:0]    n_in;

  logic [2*H-1:0]    pll [0:2];
  logic [H+HW-1:0]   plh [0:2];
  logic [2*HW-1:0]   phh [0:2];
  logic [2:0]        n1, n2, n3;
  logic [SQW-1:0]    csq [0:2];
  logic [SQW-1:0]    csq3 [0:2];
  logic [SW-1:0]     s3;
  logic [QW-1:0]     umag [0:2];
  logic [2:0]        uneg;
  logic [OW-1:0]     nrm [0:2];
  tfn_ctrl_t c1, c2, c3;
  tfn_ctrl_t upipe [0:UL-1];

  assign m_in[0] = in_item[MW-1:0];
  assign m_in[1] = in_item[2*MW-1:MW];
  assign m_in[2] = in_item[3*MW-1:2*MW];
  assign n_in    = in_item[3*MW+2:3*MW];

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      c3 <= '0;
    end else begin
      c1 <= '{valid: in_valid, degenerate: in_item[3*MW+3]};
      c2 <= c1;
      c3 <= c2;
    end
  end

  genvar k;
  generate
    for (k = 0; k < 3; k++) begin : g_comp
      // split square: three partial products, then combine
      always_ff @(posedge clk) begin
        pll[k] <= m_in[k][H-1:0] * m_in[k][H-1:0];
        plh[k] <= m_in[k][H-1:0] * m_in[k][MW-1:H];
        phh[k] <= m_in[k][MW-1:H] * m_in[k][MW-1:H];
        csq[k] <= (SQW'(phh[k]) << (2 * H)) + (SQW'(plh[k]) << (H + 1))
                  + SQW'(pll[k]);
        csq3[k] <= csq[k];
      end

      tfn_unit #(
        .NORMAL_FRAC (NORMAL_FRAC),
        .MAG_BITS    (MW)
      ) u_unit (
        .clk     (clk),
        .csq     (csq3[k]),
        .sum     (s3),
        .neg     (n3[k]),
        .mag     (umag[k]),
        .mag_neg (uneg[k])
      );

      assign nrm[k] = uneg[k] ? (-OW'(umag[k])) : OW'(umag[k]);
    end
  endgenerate

  always_ff @(posedge clk) begin
    n1 <= n_in;
    n2 <= n1;
    n3 <= n2;
    s3 <= SW'(csq[0]) + SW'(csq[1]) + SW'(csq[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < UL; p++) begin
        upipe[p] <= '0;
      end
    end else begin
      upipe[0] <= c3;
      for (int p = 1; p < UL; p++) begin
        upipe[p] <= upipe[p-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= upipe[UL-1].valid;
    end
    deg <= upipe[UL-1].degenerate;
    nx  <= upipe[UL-1].degenerate ? '0 : nrm[0];
    ny  <= upipe[UL-1].degenerate ? '0 : nrm[1];
    nz  <= upipe[UL-1].degenerate ? '0 : nrm[2];
  end

endmodule

`default_nettype wire

/* hw/rtl/triangle_face_normal.sv */
`timescale 1ns / 1ps
`default_nettype none

// Unit face normal of one triangle. Give the three vertices (signed fixed
// point, COORD_BITS wide) with start; a transaction is taken on any clock
// edge where start is high and busy is low. The block forms the edges
// (v1 - v3) and (v3 - v2), their exact cross product c, and returns
// c / |c| as signed Q1.NORMAL_FRAC, rounded toward zero, with done high for
// exactly one cycle. There is no way to hold a result off: sample it on the
// cycle done is high. A zero cross product returns an all-zero normal with
// degenerate set. One transaction is accepted per clock while busy is low, and
// results come back in order through 3 front stages (edges, products,
// cross/classify), 1 in the queue, 3 to square and sum, 2*NORMAL_FRAC+1
// division stages (one quotient bit each), NORMAL_FRAC+1 square-root stages
// (one root bit each) and the output register. busy only rises if the queue
// between the front and the back pipeline fills, which does not happen since
// the back never stalls.
module triangle_face_normal #(
  parameter int COORD_BITS  = tfn_pkg::COORD_BITS_DEF,
  parameter int NORMAL_FRAC = tfn_pkg::NORMAL_FRAC_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [COORD_BITS-1:0]  first_x,
  input  wire logic signed [COORD_BITS-1:0]  first_y,
  input  wire logic signed [COORD_BITS-1:0]  first_z,
  input  wire logic signed [COORD_BITS-1:0]  second_x,
  input  wire logic signed [COORD_BITS-1:0]  second_y,
  input  wire logic signed [COORD_BITS-1:0]  second_z,
  input  wire logic signed [COORD_BITS-1:0]  third_x,
  input  wire logic signed [COORD_BITS-1:0]  third_y,
  input  wire logic signed [COORD_BITS-1:0]  third_z,
  output logic                               done,
  output logic signed [NORMAL_FRAC+1:0]      normal_x,
  output logic signed [NORMAL_FRAC+1:0]      normal_y,
  output logic signed [NORMAL_FRAC+1:0]      normal_z,
  output logic                               degenerate
);
  import tfn_pkg::*;

  // queue entry: degenerate flag, three signs, three cross magnitudes
  localparam int IW = 3 * (2 * COORD_BITS + 1) + 4;

  logic             accept;
  logic             push;
  logic             pop;
  logic [IW-1:0]    push_item;
  logic [IW-1:0]    pop_item;
  tfn_fifo_status_t q_status;

  assign accept = start & ~busy;
  // the back pipeline takes an entry every cycle one is there
  assign pop    = ~q_status.empty;

  tfn_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .queue_full (q_status.full),
    .stall      (busy),
    .push       (push),
    .item       (push_item),
    .v1x        (first_x),
    .v1y        (first_y),
    .v1z        (first_z),
    .v2x        (second_x),
    .v2y        (second_y),
    .v2z        (second_z),
    .v3x        (third_x),
    .v3y        (third_y),
    .v3z        (third_z)
  );

  tfn_fifo #(
    .WIDTH (IW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_item),
    .pop       (pop),
    .pop_data  (pop_item),
    .status    (q_status)
  );

  tfn_back #(
    .COORD_BITS  (COORD_BITS),
    .NORMAL_FRAC (NORMAL_FRAC)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pop),
    .in_item  (pop_item),
    .done     (done),
    .nx       (normal_x),
    .ny       (normal_y),
    .nz       (normal_z),
    .deg      (degenerate)
  );

endmodule

`default_nettype wire
